// ===== hw/rtl/i2c_master_register_access_macros.svh =====
// Assertion helpers shared by the RTL files of the I2C register master.
// Each macro checks on the rising edge of clk and is switched off while
// rst_n is low.
`ifndef I2C_MASTER_REGISTER_ACCESS_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_MACROS_SVH

// A property that must hold at every edge.
`define I2CM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that, once seen, must be followed by another at the next edge.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C register-access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Item opcodes.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;
  localparam logic [1:0] OP_IGNORE = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLAVE_ADDR   = 2'd0;
  localparam logic [1:0] CFG_HALF_PERIOD  = 2'd1;
  localparam logic [1:0] CFG_ACK_TIMEOUT  = 2'd2;

  localparam logic [7:0]  HALF_PERIOD_RESET = 8'd20;
  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd20000;

  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [6:0]  slave_address;
    logic [7:0]  half_period_ticks;
    logic [15:0] ack_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic       sda_in;
    logic [7:0] data_byte;
    logic [7:0] reg_addr;
    logic       is_read;
    logic [7:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       done_res;
    logic       success;
    logic       busy_res;
    logic       rejected;
  } out_item_t;

endpackage

// ===== hw/rtl/i2cm_if.sv =====
// ----------------------------------------------------------------------------
// i2cm_if
// Channel interfaces: input items, result items and configuration writes.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       sda_in;
  logic [7:0] data_byte;
  logic [7:0] reg_addr;
  logic       is_read;
  logic [7:0] byte_count;

  modport source (output valid, output op, output sda_in, output data_byte,
                  output reg_addr, output is_read, output byte_count, input ready);
  modport sink (input valid, input op, input sda_in, input data_byte,
                input reg_addr, input is_read, input byte_count, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda;
  logic       rx_valid;
  logic [7:0] rx_data;
  logic       done_res;
  logic       success;
  logic       busy_res;
  logic       rejected;

  modport source (output valid, output scl, output sda, output rx_valid,
                  output rx_data, output done_res, output success,
                  output busy_res, output rejected, input ready);
  modport sink (input valid, input scl, input sda, input rx_valid,
                input rx_data, input done_res, input success,
                input busy_res, input rejected, output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/i2cm_core.sv =====
// ----------------------------------------------------------------------------
// i2cm_core
// Bus sequencer: one state update per accepted beat, plus the write buffer.
// ----------------------------------------------------------------------------
`include "i2c_master_register_access_macros.svh"

module i2cm_core import i2cm_pkg::*; #(
  parameter int BUF_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t res
);

  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUF_DEPTH);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_TX_SETUP, PH_TX_HIGH, PH_ACK_SETUP,
    PH_ACK_HIGH, PH_ACK_POLL, PH_ACK_LOW, PH_RX_HIGH, PH_RX_LOW,
    PH_RXACK_SETUP, PH_RXACK_HIGH, PH_RXACK_LOW, PH_STOP_A, PH_STOP_B
  } phase_t;

  typedef enum logic [1:0] {ST_ADDR_W, ST_REG, ST_DATA, ST_ADDR_R} stage_t;

  phase_t           phase_r, phase_nxt;
  stage_t           stage_r, stage_nxt;
  logic [3:0]       bit_count_r, bit_count_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [7:0]       delay_r, delay_nxt;
  logic [15:0]      timeout_r, timeout_nxt;
  logic [7:0]       bytes_left_r, bytes_left_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] send_r, send_nxt;
  logic             read_mode_r, read_mode_nxt;
  logic [7:0]       reg_addr_r, reg_addr_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic             ok_r, ok_nxt;

  logic [7:0]       buf_mem [BUF_DEPTH];
  logic [7:0]       buf_rd_r;
  logic             buf_we;

  logic [7:0]       hp_eff;
  logic [15:0]      to_eff;

  assign hp_eff = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
  assign to_eff = (cfg.ack_timeout_ticks == 16'd0) ? 16'd1 : cfg.ack_timeout_ticks;

  always_comb begin
    logic        do_go;
    phase_t      go_ph;
    logic        go_c;
    logic        go_d;
    logic        do_send;
    logic [7:0]  send_b;
    logic        do_rx;
    logic        do_stop;
    logic        do_wnext;
    logic        do_poll;
    logic [15:0] t_base;
    logic [15:0] t_dec;
    logic [3:0]  bc_inc;
    logic [7:0]  sh_in;
    logic [7:0]  bl_dec;

    phase_nxt      = phase_r;
    stage_nxt      = stage_r;
    bit_count_nxt  = bit_count_r;
    shift_nxt      = shift_r;
    delay_nxt      = delay_r;
    timeout_nxt    = timeout_r;
    bytes_left_nxt = bytes_left_r;
    fill_nxt       = fill_r;
    send_nxt       = send_r;
    read_mode_nxt  = read_mode_r;
    reg_addr_nxt   = reg_addr_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ok_nxt         = ok_r;
    buf_we         = 1'b0;

    res = '0;

    do_go    = 1'b0;
    go_ph    = phase_r;
    go_c     = scl_r;
    go_d     = sda_r;
    do_send  = 1'b0;
    send_b   = '0;
    do_rx    = 1'b0;
    do_stop  = 1'b0;
    do_wnext = 1'b0;
    do_poll  = 1'b0;
    t_base   = timeout_r;
    bc_inc   = bit_count_r + 4'd1;
    sh_in    = {shift_r[6:0], item.sda_in};
    bl_dec   = (bytes_left_r != 8'd0) ? (bytes_left_r - 8'd1) : bytes_left_r;

    if (fire) begin
      unique case (item.op)
        OP_TICK: begin
          if (phase_r == PH_ACK_POLL) begin
            do_poll = 1'b1;
          end else if (phase_r != PH_IDLE) begin
            if (delay_r > 8'd1) begin
              delay_nxt = delay_r - 8'd1;
            end else begin
              unique case (phase_r)
                PH_START_A: begin
                  do_go = 1'b1; go_ph = PH_START_B; go_c = 1'b1; go_d = 1'b0;
                end
                PH_START_B: begin
                  do_send = 1'b1;
                  send_b  = {cfg.slave_address, stage_r == ST_ADDR_R};
                end
                PH_TX_SETUP: begin
                  do_go = 1'b1; go_ph = PH_TX_HIGH; go_c = 1'b1; go_d = sda_r;
                end
                PH_TX_HIGH: begin
                  bit_count_nxt = bc_inc;
                  if (bc_inc < 4'd8) begin
                    do_go = 1'b1; go_ph = PH_TX_SETUP; go_c = 1'b0; go_d = shift_r[7];
                    shift_nxt = {shift_r[6:0], 1'b0};
                  end else begin
                    do_go = 1'b1; go_ph = PH_ACK_SETUP; go_c = 1'b0; go_d = 1'b1;
                  end
                end
                PH_ACK_SETUP: begin
                  do_go = 1'b1; go_ph = PH_ACK_HIGH; go_c = 1'b1; go_d = 1'b1;
                end
                PH_ACK_HIGH: begin
                  phase_nxt   = PH_ACK_POLL;
                  timeout_nxt = to_eff;
                  t_base      = to_eff;
                  do_poll     = 1'b1;
                end
                PH_ACK_LOW: begin
                  if (!ok_r) begin
                    do_stop = 1'b1;
                  end else begin
                    unique case (stage_r)
                      ST_ADDR_W: begin
                        stage_nxt = ST_REG;
                        do_send   = 1'b1;
                        send_b    = reg_addr_r;
                      end
                      ST_REG: begin
                        if (read_mode_r) begin
                          stage_nxt = ST_ADDR_R;
                          do_go = 1'b1; go_ph = PH_START_A; go_c = 1'b1; go_d = 1'b1;
                        end else begin
                          do_wnext = 1'b1;
                        end
                      end
                      ST_DATA:   do_wnext = 1'b1;
                      ST_ADDR_R: do_rx    = 1'b1;
                      default:   do_rx    = 1'b1;
                    endcase
                  end
                end
                PH_RX_HIGH: begin
                  shift_nxt     = sh_in;
                  bit_count_nxt = bc_inc;
                  if (bc_inc >= 4'd8) begin
                    res.rx_valid = 1'b1;
                    res.rx_data  = sh_in;
                  end
                  do_go = 1'b1; go_ph = PH_RX_LOW; go_c = 1'b0; go_d = 1'b1;
                end
                PH_RX_LOW: begin
                  if (bit_count_r < 4'd8) begin
                    do_go = 1'b1; go_ph = PH_RX_HIGH; go_c = 1'b1; go_d = 1'b1;
                  end else begin
                    // The last byte of a read is answered with a NACK.
                    do_go = 1'b1; go_ph = PH_RXACK_SETUP; go_c = 1'b0;
                    go_d  = (bytes_left_r <= 8'd1);
                  end
                end
                PH_RXACK_SETUP: begin
                  do_go = 1'b1; go_ph = PH_RXACK_HIGH; go_c = 1'b1; go_d = sda_r;
                end
                PH_RXACK_HIGH: begin
                  do_go = 1'b1; go_ph = PH_RXACK_LOW; go_c = 1'b0; go_d = sda_r;
                end
                PH_RXACK_LOW: begin
                  bytes_left_nxt = bl_dec;
                  if (bl_dec != 8'd0) begin
                    do_rx = 1'b1;
                  end else begin
                    do_stop = 1'b1;
                  end
                end
                PH_STOP_A: begin
                  do_go = 1'b1; go_ph = PH_STOP_B; go_c = 1'b1; go_d = 1'b1;
                end
                PH_STOP_B: begin
                  phase_nxt    = PH_IDLE;
                  delay_nxt    = 8'd0;
                  res.done_res = 1'b1;
                  res.success  = ok_r;
                  fill_nxt     = '0;
                  send_nxt     = '0;
                end
                default: phase_nxt = PH_IDLE;
              endcase
            end
          end
        end
        OP_LOAD: begin
          if (phase_r != PH_IDLE || fill_r >= DEPTH_C) begin
            res.rejected = 1'b1;
          end else begin
            buf_we   = 1'b1;
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
        OP_START: begin
          if (phase_r != PH_IDLE) begin
            res.rejected = 1'b1;
          end else begin
            reg_addr_nxt   = item.reg_addr;
            read_mode_nxt  = item.is_read;
            bytes_left_nxt = (item.byte_count == 8'd0) ? 8'd1 : item.byte_count;
            stage_nxt      = ST_ADDR_W;
            ok_nxt         = 1'b0;
            send_nxt       = '0;
            do_go = 1'b1; go_ph = PH_START_A; go_c = 1'b1; go_d = 1'b1;
          end
        end
        OP_IGNORE: begin
        end
        default: begin
        end
      endcase
    end

    // Acknowledge poll: a low SDA ends it, otherwise the budget counts down.
    if (do_poll) begin
      t_dec = t_base - 16'd1;
      if (!item.sda_in) begin
        ok_nxt = 1'b1;
        do_go = 1'b1; go_ph = PH_ACK_LOW; go_c = 1'b0; go_d = 1'b1;
      end else begin
        timeout_nxt = t_dec;
        if (t_dec == 16'd0) begin
          ok_nxt = 1'b0;
          do_go = 1'b1; go_ph = PH_ACK_LOW; go_c = 1'b0; go_d = 1'b1;
        end
      end
    end else begin
      t_dec = t_base;
    end

    if (do_wnext) begin
      if (send_r < fill_r && send_r < DEPTH_C) begin
        stage_nxt = ST_DATA;
        do_send   = 1'b1;
        send_b    = buf_rd_r;
        send_nxt  = send_r + CNT_W'(1);
      end else begin
        do_stop = 1'b1;
      end
    end

    if (do_stop) begin
      do_go = 1'b1; go_ph = PH_STOP_A; go_c = 1'b1; go_d = 1'b0;
    end

    if (do_rx) begin
      bit_count_nxt = 4'd0;
      shift_nxt     = 8'd0;
      do_go = 1'b1; go_ph = PH_RX_HIGH; go_c = 1'b1; go_d = 1'b1;
    end

    if (do_send) begin
      shift_nxt     = {send_b[6:0], 1'b0};
      bit_count_nxt = 4'd0;
      do_go = 1'b1; go_ph = PH_TX_SETUP; go_c = 1'b0; go_d = send_b[7];
    end

    if (do_go) begin
      phase_nxt = go_ph;
      scl_nxt   = go_c;
      sda_nxt   = go_d;
      delay_nxt = hp_eff;
    end

    res.scl      = scl_nxt;
    res.sda      = sda_nxt;
    res.busy_res = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      stage_r      <= ST_ADDR_W;
      bit_count_r  <= '0;
      shift_r      <= '0;
      delay_r      <= '0;
      timeout_r    <= '0;
      bytes_left_r <= '0;
      fill_r       <= '0;
      send_r       <= '0;
      read_mode_r  <= 1'b0;
      reg_addr_r   <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      ok_r         <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      stage_r      <= stage_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_r      <= shift_nxt;
      delay_r      <= delay_nxt;
      timeout_r    <= timeout_nxt;
      bytes_left_r <= bytes_left_nxt;
      fill_r       <= fill_nxt;
      send_r       <= send_nxt;
      read_mode_r  <= read_mode_nxt;
      reg_addr_r   <= reg_addr_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      ok_r         <= ok_nxt;
    end
  end

  // The buffer is only written while idle, and the next byte to send is read
  // long before it is needed, so a registered read port is enough.
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[fill_r[IDX_W-1:0]] <= item.data_byte;
    end
    buf_rd_r <= buf_mem[send_r[IDX_W-1:0]];
  end

  `I2CM_ASSERT(a_fill_in_range, fill_r <= DEPTH_C, "write buffer fill count beyond depth")
  `I2CM_ASSERT(a_send_le_fill, send_r <= fill_r, "send index ran past the buffered bytes")
  `I2CM_ASSERT(a_idle_released, (phase_r != PH_IDLE) || (scl_r && sda_r),
    "bus lines not released while idle")
  `I2CM_ASSERT_NEXT(a_start_busy, fire && item.op == OP_START && phase_r == PH_IDLE,
    phase_r == PH_START_A, "accepted start did not open a transaction")

endmodule

// ===== hw/rtl/i2cm_skid.sv =====
// ----------------------------------------------------------------------------
// i2cm_skid
// Two-entry result register: output register plus one skid entry.
// ----------------------------------------------------------------------------
`include "i2c_master_register_access_macros.svh"

module i2cm_skid import i2cm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      push_ready,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_ready
);

  logic      main_v_r;
  out_item_t main_d_r;
  logic      skid_v_r;
  out_item_t skid_d_r;

  assign push_ready = !skid_v_r;
  assign out_valid  = main_v_r;
  assign out_data   = main_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!main_v_r || out_ready) begin
        // Output register free this cycle: refill from skid first.
        if (skid_v_r) begin
          main_v_r <= 1'b1;
          main_d_r <= skid_d_r;
          skid_v_r <= 1'b0;
        end else begin
          main_v_r <= push;
          main_d_r <= push_data;
        end
      end else if (push) begin
        skid_v_r <= 1'b1;
        skid_d_r <= push_data;
      end
    end
  end

  `I2CM_ASSERT(a_skid_behind_main, !skid_v_r || main_v_r, "skid entry held without output beat")
  `I2CM_ASSERT_NEXT(a_main_holds, main_v_r && !out_ready,
    main_v_r && $stable(main_d_r), "stalled result beat changed")
  `I2CM_ASSERT_NEXT(a_skid_holds, skid_v_r && !out_ready,
    skid_v_r && $stable(skid_d_r), "skid entry lost while stalled")

endmodule

// ===== hw/rtl/i2c_master_register_access.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_access
// Register-addressed I2C master driven by tick, load and start beats.
// ----------------------------------------------------------------------------
// Every input beat yields exactly one result beat, and a beat can be taken on
// every clock: the sequencer updates its state once per accepted beat, and a
// two-entry result register lets the input keep flowing while a result waits.
// The input stalls only once both result entries are full. Bus timing is set
// entirely by the tick beats (half_period_ticks per bus delay), not by clk.
// Write bytes go into a BUF_DEPTH-entry buffer with a registered read port;
// configuration writes are always accepted and should be made while idle.

module i2c_master_register_access import i2cm_pkg::*; #(
  parameter int BUF_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  i2cm_cfg_if.sink      cfg_ch,
  i2cm_in_if.sink       in_ch,
  i2cm_out_if.source    out_ch
);

  cfg_t      cfg_r;
  in_item_t  item;
  out_item_t res;
  out_item_t out_d;
  logic      fire;
  logic      push_ready;
  logic      cfg_we;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_address     <= '0;
      cfg_r.half_period_ticks <= HALF_PERIOD_RESET;
      cfg_r.ack_timeout_ticks <= ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_ch.index)
        CFG_SLAVE_ADDR:  cfg_r.slave_address     <= cfg_ch.data[6:0];
        CFG_HALF_PERIOD: cfg_r.half_period_ticks <= cfg_ch.data[7:0];
        CFG_ACK_TIMEOUT: cfg_r.ack_timeout_ticks <= cfg_ch.data[CFG_DATA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign item.op         = in_ch.op;
  assign item.sda_in     = in_ch.sda_in;
  assign item.data_byte  = in_ch.data_byte;
  assign item.reg_addr   = in_ch.reg_addr;
  assign item.is_read    = in_ch.is_read;
  assign item.byte_count = in_ch.byte_count;

  assign in_ch.ready = push_ready;
  assign fire        = in_ch.valid && push_ready;

  i2cm_core #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (fire),
    .item  (item),
    .res   (res)
  );

  i2cm_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .push_data  (res),
    .push_ready (push_ready),
    .out_valid  (out_ch.valid),
    .out_data   (out_d),
    .out_ready  (out_ch.ready)
  );

  assign out_ch.scl      = out_d.scl;
  assign out_ch.sda      = out_d.sda;
  assign out_ch.rx_valid = out_d.rx_valid;
  assign out_ch.rx_data  = out_d.rx_data;
  assign out_ch.done_res = out_d.done_res;
  assign out_ch.success  = out_d.success;
  assign out_ch.busy_res = out_d.busy_res;
  assign out_ch.rejected = out_d.rejected;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the register-addressed I2C master. Directed tests
// cover reset settings, a full write buffer, zero timing values, the largest
// acknowledge timeout, missing acknowledges and a multi-byte read. Random
// register transfers follow. A bus-level model in the bench predicts every
// result beat, and a checker compares each accepted result with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module tb;
  import i2cm_pkg::*;

  localparam int BUF_DEPTH   = 16;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [4:0] {
    BP_IDLE, BP_START_A, BP_START_B, BP_TX_SETUP, BP_TX_HIGH, BP_ACK_SETUP,
    BP_ACK_HIGH, BP_ACK_POLL, BP_ACK_LOW, BP_RX_HIGH, BP_RX_LOW,
    BP_RXACK_SETUP, BP_RXACK_HIGH, BP_RXACK_LOW, BP_STOP_A, BP_STOP_B
  } bus_phase_t;

  typedef enum logic [1:0] {SEG_ADDR_W, SEG_REG, SEG_DATA, SEG_ADDR_R} segment_t;

  logic clk;
  logic rst_n;

  i2cm_cfg_if cfg_ch();
  i2cm_in_if  in_ch();
  i2cm_out_if out_ch();

  i2c_master_register_access #(.BUF_DEPTH(BUF_DEPTH)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Register settings as the master sees them.
  logic [6:0]  c_addr = 7'd0;
  logic [7:0]  c_half = HALF_PERIOD_RESET;
  logic [15:0] c_tmo  = ACK_TIMEOUT_RESET;

  // Bus sequencer state of the master.
  bus_phase_t  m_phase   = BP_IDLE;
  segment_t    m_seg     = SEG_ADDR_W;
  logic [3:0]  m_bits    = '0;
  logic [7:0]  m_shift   = '0;
  logic [7:0]  m_delay   = '0;
  logic [15:0] m_timeout = '0;
  logic [7:0]  m_left    = '0;
  logic [7:0]  m_buf [BUF_DEPTH];
  logic [4:0]  m_fill    = '0;
  logic [4:0]  m_sent    = '0;
  logic        m_read    = 1'b0;
  logic [7:0]  m_reg     = '0;
  logic        m_scl     = 1'b1;
  logic        m_sda     = 1'b1;
  logic        m_ok      = 1'b0;

  out_item_t expected_beats [$];
  int        failures       = 0;
  int        accepted_items = 0;
  int        ack_pct        = 100;
  bit        idle_en        = 1'b1;
  bit        hold_request   = 1'b0;
  int        cycle_count    = 0;

  function automatic void bus_move(bus_phase_t p, logic c, logic d);
    m_phase = p;
    m_scl   = c;
    m_sda   = d;
    m_delay = (c_half != 8'd0) ? c_half : 8'd1;
  endfunction

  function automatic void shift_out_bit();
    bus_move(BP_TX_SETUP, 1'b0, m_shift[7]);
    m_shift = {m_shift[6:0], 1'b0};
  endfunction

  function automatic void send_byte(logic [7:0] b);
    m_shift = b;
    m_bits  = '0;
    shift_out_bit();
  endfunction

  function automatic void open_rx_byte();
    m_bits  = '0;
    m_shift = '0;
    bus_move(BP_RX_HIGH, 1'b1, 1'b1);
  endfunction

  function automatic void next_write_byte();
    if (m_sent < m_fill && m_sent < BUF_DEPTH) begin
      m_seg = SEG_DATA;
      send_byte(m_buf[m_sent[3:0]]);
      m_sent = m_sent + 5'd1;
    end else begin
      bus_move(BP_STOP_A, 1'b1, 1'b0);
    end
  endfunction

  function automatic void sample_ack(logic line);
    if (!line) begin
      m_ok = 1'b1;
      bus_move(BP_ACK_LOW, 1'b0, 1'b1);
    end else begin
      m_timeout = m_timeout - 16'd1;
      if (m_timeout == 16'd0) begin
        m_ok = 1'b0;
        bus_move(BP_ACK_LOW, 1'b0, 1'b1);
      end
    end
  endfunction

  // Applies one beat to the master state and returns the result it gives.
  function automatic out_item_t step_master(in_item_t it);
    out_item_t r;
    logic      rej;
    r   = '0;
    rej = 1'b0;
    case (it.op)
      OP_TICK: begin
        if (m_phase == BP_ACK_POLL) begin
          sample_ack(it.sda_in);
        end else if (m_phase != BP_IDLE) begin
          if (m_delay > 8'd1) begin
            m_delay = m_delay - 8'd1;
          end else begin
            case (m_phase)
              BP_START_A:   bus_move(BP_START_B, 1'b1, 1'b0);
              BP_START_B:   send_byte({c_addr, m_seg == SEG_ADDR_R});
              BP_TX_SETUP:  bus_move(BP_TX_HIGH, 1'b1, m_sda);
              BP_TX_HIGH: begin
                m_bits = m_bits + 4'd1;
                if (m_bits < 4'd8) shift_out_bit();
                else bus_move(BP_ACK_SETUP, 1'b0, 1'b1);
              end
              BP_ACK_SETUP: bus_move(BP_ACK_HIGH, 1'b1, 1'b1);
              BP_ACK_HIGH: begin
                m_phase   = BP_ACK_POLL;
                m_timeout = (c_tmo != 16'd0) ? c_tmo : 16'd1;
                sample_ack(it.sda_in);
              end
              BP_ACK_LOW: begin
                if (!m_ok) begin
                  bus_move(BP_STOP_A, 1'b1, 1'b0);
                end else begin
                  case (m_seg)
                    SEG_ADDR_W: begin
                      m_seg = SEG_REG;
                      send_byte(m_reg);
                    end
                    SEG_REG: begin
                      if (m_read) begin
                        m_seg = SEG_ADDR_R;
                        bus_move(BP_START_A, 1'b1, 1'b1);
                      end else begin
                        next_write_byte();
                      end
                    end
                    SEG_DATA: next_write_byte();
                    default:  open_rx_byte();
                  endcase
                end
              end
              BP_RX_HIGH: begin
                m_shift = {m_shift[6:0], it.sda_in};
                m_bits  = m_bits + 4'd1;
                if (m_bits >= 4'd8) begin
                  r.rx_valid = 1'b1;
                  r.rx_data  = m_shift;
                end
                bus_move(BP_RX_LOW, 1'b0, 1'b1);
              end
              BP_RX_LOW: begin
                if (m_bits < 4'd8) bus_move(BP_RX_HIGH, 1'b1, 1'b1);
                else bus_move(BP_RXACK_SETUP, 1'b0, m_left <= 8'd1);
              end
              BP_RXACK_SETUP: bus_move(BP_RXACK_HIGH, 1'b1, m_sda);
              BP_RXACK_HIGH:  bus_move(BP_RXACK_LOW, 1'b0, m_sda);
              BP_RXACK_LOW: begin
                if (m_left > 8'd0) m_left = m_left - 8'd1;
                if (m_left > 8'd0) open_rx_byte();
                else bus_move(BP_STOP_A, 1'b1, 1'b0);
              end
              BP_STOP_A: bus_move(BP_STOP_B, 1'b1, 1'b1);
              BP_STOP_B: begin
                m_phase    = BP_IDLE;
                m_delay    = '0;
                r.done_res = 1'b1;
                r.success  = m_ok;
                m_fill     = '0;
                m_sent     = '0;
              end
              default: m_phase = BP_IDLE;
            endcase
          end
        end
      end
      OP_LOAD: begin
        if (m_phase != BP_IDLE || m_fill >= BUF_DEPTH) begin
          rej = 1'b1;
        end else begin
          m_buf[m_fill[3:0]] = it.data_byte;
          m_fill = m_fill + 5'd1;
        end
      end
      OP_START: begin
        if (m_phase != BP_IDLE) begin
          rej = 1'b1;
        end else begin
          m_reg  = it.reg_addr;
          m_read = it.is_read;
          m_left = (it.byte_count == 8'd0) ? 8'd1 : it.byte_count;
          m_seg  = SEG_ADDR_W;
          m_ok   = 1'b0;
          m_sent = '0;
          bus_move(BP_START_A, 1'b1, 1'b1);
        end
      end
      default: ;
    endcase
    r.scl      = m_scl;
    r.sda      = m_sda;
    r.busy_res = (m_phase != BP_IDLE);
    r.rejected = rej;
    return r;
  endfunction

  // The slave acknowledges with probability ack_pct; elsewhere the line is random.
  function automatic logic pick_sda();
    if (m_phase == BP_ACK_POLL || (m_phase == BP_ACK_HIGH && m_delay <= 8'd1))
      return ($urandom_range(0, 99) < ack_pct) ? 1'b0 : 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic in_item_t rand_item(logic [1:0] op);
    in_item_t it;
    it.op         = op;
    it.sda_in     = pick_sda();
    it.data_byte  = 8'($urandom_range(0, 255));
    it.reg_addr   = 8'($urandom_range(0, 255));
    it.is_read    = 1'($urandom_range(0, 1));
    it.byte_count = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
      failures++;
    end
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_beat(in_item_t it);
    out_item_t want;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= it.op;
    in_ch.sda_in     <= it.sda_in;
    in_ch.data_byte  <= it.data_byte;
    in_ch.reg_addr   <= it.reg_addr;
    in_ch.is_read    <= it.is_read;
    in_ch.byte_count <= it.byte_count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = step_master(it);
    expected_beats.push_back(want);
    if (it.op != OP_IGNORE && !want.rejected) accepted_items++;
  endtask

  task automatic load_beat(logic [7:0] b);
    in_item_t it;
    it           = rand_item(OP_LOAD);
    it.data_byte = b;
    send_beat(it);
  endtask

  task automatic start_beat(logic [7:0] reg_a, logic rd, logic [7:0] cnt);
    in_item_t it;
    it            = rand_item(OP_START);
    it.reg_addr   = reg_a;
    it.is_read    = rd;
    it.byte_count = cnt;
    send_beat(it);
  endtask

  // Ticks the bus until the transaction ends, with stray beats mixed in if asked.
  task automatic run_until_idle(bit noise);
    logic [1:0] stray;
    while (m_phase != BP_IDLE) begin
      if (noise && $urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 2))
          0:       stray = OP_LOAD;
          1:       stray = OP_START;
          default: stray = OP_IGNORE;
        endcase
        send_beat(rand_item(stray));
      end else begin
        send_beat(rand_item(OP_TICK));
      end
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_SLAVE_ADDR:  c_addr = data[6:0];
      CFG_HALF_PERIOD: c_half = data[7:0];
      CFG_ACK_TIMEOUT: c_tmo  = data;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Unused upper bits of the address and half-period writes carry random values.
  task automatic configure(logic [6:0] addr, logic [7:0] half, logic [15:0] tmo);
    settle();
    write_reg(CFG_SLAVE_ADDR, {9'($urandom_range(0, 511)), addr});
    write_reg(CFG_HALF_PERIOD, {8'($urandom_range(0, 255)), half});
    write_reg(CFG_ACK_TIMEOUT, tmo);
  endtask

  task automatic run_random_transfer();
    int         n;
    logic       rd;
    logic [7:0] cnt;
    ack_pct = ($urandom_range(0, 5) == 0) ? 40 : 95;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 3);
    repeat (n) load_beat(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 15) == 0) send_beat(rand_item(OP_IGNORE));
    rd  = 1'($urandom_range(0, 1));
    cnt = rd ? 8'($urandom_range(0, 4)) : 8'($urandom_range(0, 255));
    start_beat(8'($urandom_range(0, 255)), rd, cnt);
    run_until_idle(1'b1);
    repeat ($urandom_range(0, 2)) send_beat(rand_item(OP_TICK));
  endtask

  task automatic test_defaults();
    ack_pct = 100;
    send_beat(rand_item(OP_IGNORE));
    send_beat(rand_item(OP_TICK));
    start_beat(8'h00, 1'b0, 8'h00);
    run_until_idle(1'b0);
  endtask

  task automatic test_full_buffer();
    configure(7'h7F, 8'd1, 16'd3);
    ack_pct = 100;
    load_beat(8'h00);
    load_beat(8'hFF);
    load_beat(8'h80);
    load_beat(8'h01);
    // Thirteen more beats: the last finds the buffer full.
    repeat (13) load_beat(8'($urandom_range(0, 255)));
    start_beat(8'hFF, 1'b0, 8'hFF);
    load_beat(8'hA5);
    start_beat(8'h12, 1'b1, 8'h02);
    run_until_idle(1'b0);
  endtask

  task automatic test_reads();
    configure(7'h2A, 8'd0, 16'd0);
    ack_pct = 100;
    load_beat(8'h3C);
    load_beat(8'hC3);
    start_beat(8'h40, 1'b1, 8'h00);
    run_until_idle(1'b0);
    // The read emptied the buffer, so only the register address goes out.
    start_beat(8'h41, 1'b0, 8'h00);
    run_until_idle(1'b0);
    start_beat(8'h42, 1'b1, 8'h03);
    run_until_idle(1'b0);
  endtask

  task automatic test_ack_timeout();
    configure(7'h00, 8'd1, 16'd1);
    ack_pct = 0;
    start_beat(8'h10, 1'b0, 8'h00);
    run_until_idle(1'b0);
    configure(7'h01, 8'd1, 16'd6);
    ack_pct = 50;
    repeat (3) load_beat(8'($urandom_range(0, 255)));
    start_beat(8'h20, 1'b0, 8'h00);
    run_until_idle(1'b0);
    start_beat(8'h21, 1'b1, 8'h02);
    run_until_idle(1'b0);
  endtask

  task automatic test_long_read();
    configure(7'h55, 8'd1, 16'd2);
    ack_pct = 100;
    start_beat(8'h80, 1'b1, 8'h04);
    run_until_idle(1'b0);
  endtask

  task automatic test_slow_bus();
    configure(7'h55, 8'd2, 16'd65535);
    ack_pct = 100;
    start_beat(8'h01, 1'b0, 8'h00);
    run_until_idle(1'b0);
  endtask

  // The result side stops for a long stretch while beats keep coming.
  task automatic test_backpressure();
    configure(7'($urandom_range(0, 127)), 8'd1, 16'd4);
    hold_request = 1'b1;
    run_random_transfer();
    run_random_transfer();
  endtask

  task automatic test_random_traffic(int target, logic [7:0] half, logic [15:0] tmo);
    int first;
    configure(7'($urandom_range(0, 127)), half, tmo);
    first = accepted_items;
    while (accepted_items - first < target) run_random_transfer();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : result_ready
    int held;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        out_ch.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual scl %b sda %b rx %b",
                 $time, out_ch.scl, out_ch.sda, out_ch.rx_valid);
        failures++;
      end else begin
        want = expected_beats.pop_front();
        check_field("scl", want.scl, out_ch.scl);
        check_field("sda", want.sda, out_ch.sda);
        check_field("rx_valid", want.rx_valid, out_ch.rx_valid);
        check_field("rx_data", want.rx_data, out_ch.rx_data);
        check_field("done_res", want.done_res, out_ch.done_res);
        check_field("success", want.success, out_ch.success);
        check_field("busy_res", want.busy_res, out_ch.busy_res);
        check_field("rejected", want.rejected, out_ch.rejected);
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_TICK;
    in_ch.sda_in     <= 1'b1;
    in_ch.data_byte  <= '0;
    in_ch.reg_addr   <= '0;
    in_ch.is_read    <= 1'b0;
    in_ch.byte_count <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_SLAVE_ADDR;
    cfg_ch.data      <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_full_buffer();
    test_reads();
    test_ack_timeout();
    test_long_read();
    test_slow_bus();
    test_backpressure();
    test_random_traffic(60, 8'd1, 16'd1);
    test_random_traffic(60, 8'd2, 16'd5);
    test_random_traffic(60, 8'($urandom_range(1, 3)), 16'($urandom_range(2, 8)));
    idle_en = 1'b0;
    test_random_traffic(60, 8'd1, 16'd3);

    settle();
    repeat (16) @(posedge clk);
    if (failures == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_if.sv
hw/rtl/i2cm_core.sv
hw/rtl/i2cm_skid.sv
hw/rtl/i2c_master_register_access.sv
sim/tb.sv
